// ===== rtl/fpsa_pkg.sv =====
// Shared constants, types and helpers for the free page stack allocator.
package fpsa_pkg;

  localparam int PAGE_BITS = 12;
  localparam int MAX_PAGES = 32768;
  localparam int ADDR_BITS = 32;

  localparam int PN_BITS  = ADDR_BITS - PAGE_BITS;
  localparam int IDX_BITS = $clog2(MAX_PAGES);
  localparam int CNT_BITS = $clog2(MAX_PAGES + 1);

  localparam int PORT_ADDR_BITS = 32;
  localparam int PORT_CNT_BITS  = 16;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_END   = 1'd1;

  localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_END_RST   = 32'h8800_0000;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_POP        = 3'd1;
  localparam logic [2:0] OP_PUSH_FREE  = 3'd2;
  localparam logic [2:0] OP_INIT_LOAD  = 3'd3;
  localparam logic [2:0] OP_PUSH_INIT  = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       load_out;
    logic [1:0] out_status;
    logic       out_from_ram;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic bad_free;
    logic init_done;
  } dp_sts_t;

  // port address -> internal address width (modulo 2^ADDR_BITS)
  function automatic logic [ADDR_BITS-1:0] to_addr(input logic [PORT_ADDR_BITS-1:0] v);
    logic [ADDR_BITS+PORT_ADDR_BITS-1:0] t;
    t = {ADDR_BITS'(0), v};
    return t[ADDR_BITS-1:0];
  endfunction

  // internal address -> port width
  function automatic logic [PORT_ADDR_BITS-1:0] to_port_addr(input logic [ADDR_BITS-1:0] v);
    logic [ADDR_BITS+PORT_ADDR_BITS-1:0] t;
    t = {PORT_ADDR_BITS'(0), v};
    return t[PORT_ADDR_BITS-1:0];
  endfunction

  // count -> low bits of the reported free count
  function automatic logic [PORT_CNT_BITS-1:0] to_port_cnt(input logic [CNT_BITS-1:0] v);
    logic [CNT_BITS+PORT_CNT_BITS-1:0] t;
    t = {PORT_CNT_BITS'(0), v};
    return t[PORT_CNT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/fpsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fpsa_datapath.sv =====
// Datapath: region registers, stack pointer, init walker, stack RAM and result registers.
module fpsa_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fpsa_pkg::dp_cmd_t                    cmd,
  output fpsa_pkg::dp_sts_t                    sts,
  input  logic [fpsa_pkg::PORT_ADDR_BITS-1:0]  in_page_addr,
  input  logic                                 cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic [fpsa_pkg::PORT_ADDR_BITS-1:0]  out_alloc_addr,
  output logic [1:0]                           out_status,
  output logic [fpsa_pkg::PORT_CNT_BITS-1:0]   out_free_count
);
  import fpsa_pkg::*;

  logic [31:0]               region_start_r;
  logic [31:0]               region_end_r;
  logic [CNT_BITS-1:0]       count_r, count_nxt, count_dec;
  logic [PN_BITS:0]          pn_r, pn_nxt;
  logic [PN_BITS:0]          pend_r, pend_nxt;
  logic [ADDR_BITS-1:0]      start_a, end_a, page_a;
  logic [PN_BITS:0]          pstart;
  logic                      ram_we, ram_re;
  logic [IDX_BITS-1:0]       ram_waddr, ram_raddr;
  logic [PN_BITS-1:0]        ram_wdata, ram_rdata;
  logic [PORT_ADDR_BITS-1:0] out_alloc_addr_r;
  logic [1:0]                out_status_r;
  logic [PORT_CNT_BITS-1:0]  out_free_count_r;

  assign start_a = to_addr(region_start_r);
  assign end_a   = to_addr(region_end_r);
  assign page_a  = to_addr(in_page_addr);

  // first whole page at or above region start
  assign pstart = {1'b0, start_a[ADDR_BITS-1:PAGE_BITS]}
                + {{PN_BITS{1'b0}}, (start_a[PAGE_BITS-1:0] != '0)};

  assign count_dec = count_r - CNT_BITS'(1);

  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CNT_BITS'(MAX_PAGES));
  assign sts.bad_free  = (page_a[PAGE_BITS-1:0] != '0) || (page_a < start_a) ||
                         (page_a >= end_a);
  assign sts.init_done = (pn_r >= pend_r);

  always_comb begin
    count_nxt = count_r;
    pn_nxt    = pn_r;
    pend_nxt  = pend_r;
    case (cmd.op)
      OP_POP:       count_nxt = count_dec;
      OP_PUSH_FREE: count_nxt = count_r + CNT_BITS'(1);
      OP_PUSH_INIT: begin
        count_nxt = count_r + CNT_BITS'(1);
        pn_nxt    = pn_r + (PN_BITS+1)'(1);
      end
      OP_INIT_LOAD: begin
        count_nxt = '0;
        pn_nxt    = pstart;
        pend_nxt  = {1'b0, end_a[ADDR_BITS-1:PAGE_BITS]};
      end
      default:      count_nxt = count_r;
    endcase
  end

  assign ram_we    = (cmd.op == OP_PUSH_FREE) || (cmd.op == OP_PUSH_INIT);
  assign ram_waddr = count_r[IDX_BITS-1:0];
  assign ram_wdata = (cmd.op == OP_PUSH_INIT) ? pn_r[PN_BITS-1:0]
                                               : page_a[ADDR_BITS-1:PAGE_BITS];
  assign ram_re    = (cmd.op == OP_POP);
  assign ram_raddr = count_dec[IDX_BITS-1:0];

  fpsa_ram #(
    .WIDTH (PN_BITS),
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= REGION_START_RST;
      region_end_r   <= REGION_END_RST;
      count_r        <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we && cfg_index == CFG_REGION_START) begin
        region_start_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_REGION_END) begin
        region_end_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pn_r   <= pn_nxt;
    pend_r <= pend_nxt;
    if (cmd.load_out) begin
      out_alloc_addr_r <= cmd.out_from_ram ?
                          to_port_addr({ram_rdata, PAGE_BITS'(0)}) : '0;
      out_status_r     <= cmd.out_status;
      out_free_count_r <= to_port_cnt(count_nxt);
    end
  end

  assign out_alloc_addr = out_alloc_addr_r;
  assign out_status     = out_status_r;
  assign out_free_count = out_free_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_PAGES))
    else $error("stack count above capacity");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_POP |-> count_r != '0)
    else $error("pop issued on empty stack");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !sts.full)
    else $error("push issued on full stack");

endmodule

// ===== rtl/fpsa_ctrl.sv =====
// Request sequencer: decodes requests, steps init walk and alloc read, flags results.
module fpsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_req_type,
  output logic              busy,
  output logic              out_valid,
  output fpsa_pkg::dp_cmd_t cmd,
  input  fpsa_pkg::dp_sts_t sts
);
  import fpsa_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_ALLOC_RD = 2'd1;
  localparam logic [1:0] S_INIT_RUN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: OP_NONE, load_out: 1'b0, out_status: STAT_OK, out_from_ram: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_ALLOC: begin
              if (sts.empty) begin
                cmd.load_out   = 1'b1;
                cmd.out_status = STAT_OOM;
              end else begin
                cmd.op    = OP_POP;
                state_nxt = S_ALLOC_RD;
              end
            end
            REQ_FREE: begin
              cmd.load_out = 1'b1;
              if (sts.bad_free) begin
                cmd.out_status = STAT_BAD;
              end else if (sts.full) begin
                cmd.out_status = STAT_FULL;
              end else begin
                cmd.op = OP_PUSH_FREE;
              end
            end
            REQ_INIT: begin
              cmd.op    = OP_INIT_LOAD;
              state_nxt = S_INIT_RUN;
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        cmd.load_out     = 1'b1;
        cmd.out_from_ram = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_INIT_RUN: begin
        if (sts.init_done) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.full) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = STAT_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op = OP_PUSH_INIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.load_out;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC_RD |=> out_valid_r && state_r == S_IDLE)
    else $error("alloc read did not produce a result");

  a_init_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT_RUN && !sts.init_done && !sts.full) |=>
      state_r == S_INIT_RUN && !out_valid_r)
    else $error("init walk ended early");

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) || (state_r == S_ALLOC_RD) || (state_r == S_INIT_RUN))
    else $error("sequencer in unknown state");

endmodule

// ===== rtl/free_page_stack_allocator_top.sv =====
// Free page stack allocator: LIFO of free page numbers with alloc, free and init requests.
// Free, failed alloc and unknown requests load the result registers at the accept edge itself;
// alloc adds the registered stack RAM read; init loads the walker, then pushes one page per cycle.
// Throughput: one free per cycle; busy is high during alloc read and init walk.
// Synchronous active-low reset empties the stack count and reloads region defaults.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
module free_page_stack_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // request beat
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_req_type,
  input  logic [fpsa_pkg::PORT_ADDR_BITS-1:0] in_page_addr,
  // result beat
  output logic                                out_valid,
  output logic [fpsa_pkg::PORT_ADDR_BITS-1:0] out_alloc_addr,
  output logic [1:0]                          out_status,
  output logic [fpsa_pkg::PORT_CNT_BITS-1:0]  out_free_count,
  // register write beat
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data
);
  import fpsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // region registers are always writable; writes must happen only while idle (not enforced here)
  assign cfg_ready = 1'b1;

  // sequencer: request decode, alloc read wait, init walk
  fpsa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .busy        (busy),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .sts         (sts)
  );

  // datapath: stack RAM, count, region bounds check, result registers
  fpsa_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_page_addr   (in_page_addr),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_alloc_addr (out_alloc_addr),
    .out_status     (out_status),
    .out_free_count (out_free_count)
  );

endmodule
